// ===== rtl/core/lpsd_pkg.sv =====
// Package for the lift position sensor decoder.
// Holds the slot type, reset constants, pin bit positions and the volts conversion.
// Depends on nothing; imported by lift_position_sensor_decoder_unit.
`default_nettype none

package lpsd_pkg;

    localparam int SAMPLE_W    = 23;
    localparam int VOLTS_W     = 3;
    localparam int LIMIT_W     = 8;
    localparam int QUIET_W     = 8;
    localparam int INDEX_W     = 3;
    localparam int SLOT_COUNT  = 4;
    localparam int PIN_COUNT   = 5;
    localparam int VOLT_SCALE  = 1000000;
    localparam int VOLTS_MAX   = 7;

    localparam logic [LIMIT_W-1:0] QUIET_RESET = 8'd15;
    localparam logic [QUIET_W-1:0] QUIET_MAX   = 8'd255;
    localparam logic [INDEX_W-1:0] INDEX_LAST  = 3'd2;
    localparam logic [INDEX_W-1:0] INDEX_FULL  = 3'd3;

    typedef logic signed [3:0] slot_t;

    localparam slot_t SLOT_EMPTY = -4'sd1;

    localparam int PIN_UP    = 0;
    localparam int PIN_DOWN  = 1;
    localparam int PIN_BELOW = 2;
    localparam int PIN_LEVEL = 3;
    localparam int PIN_ABOVE = 4;

    // Whole volts, truncated and saturated at seven, from seven independent threshold compares.
    function automatic logic [VOLTS_W-1:0] volts_of(input logic [SAMPLE_W-1:0] sample);
        logic [VOLTS_W-1:0] v;
        v = '0;
        for (int k = 1; k <= VOLTS_MAX; k++)
        begin
            if ({9'd0, sample} >= 32'(k * VOLT_SCALE))
            begin
                v = VOLTS_W'(k);
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lift_position_sensor_decoder_unit.sv =====
// Lift position sensor decoder: converts samples to volts, keeps the reading record and pins.
// Depends on lpsd_pkg for types, constants and the volts conversion.
//
// Channel   Dir  Accept                      Contents
// s_axis    in   s_axis_tvalid & tready      sample_microvolts
// m_axis    out  m_axis_tvalid & tready      lamps and pin levels
// cfg       in   cfg_wr_en                   quiet_tick_limit
//
// A word is registered in the input register (converted to volts there) and passes
// through the update logic before it reaches the result register. One word per cycle
// is sustained while the result register is not stalled. The record update sits in that
// single update stage. A stalled result register holds the update stage; the input
// register takes one more word only while empty. Reset clears the record to empty slots.
`default_nettype none

module lift_position_sensor_decoder_unit
    import lpsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [22:0] sample_microvolts, [23] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [0] green_lamp, [1] red_lamp, [2] up_pin,
                                            // [3] down_pin, [4] below_pin, [5] level_pin,
                                            // [6] above_pin, [7] zero
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    logic                 in_valid_reg;
    logic [VOLTS_W-1:0]   volts_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;
    logic [7:0]           out_data_next;
    logic [LIMIT_W-1:0]   limit_reg;

    slot_t                slots_reg [SLOT_COUNT];
    slot_t                slots_next [SLOT_COUNT];
    logic [INDEX_W-1:0]   widx_reg;
    logic [INDEX_W-1:0]   widx_next;
    logic [INDEX_W-1:0]   widx_eff;
    logic [QUIET_W-1:0]   quiet_reg;
    logic [QUIET_W-1:0]   quiet_next;
    logic                 stop_reg;
    logic                 stop_next;
    logic [PIN_COUNT-1:0] pins_reg;
    logic [PIN_COUNT-1:0] pins_next;

    logic                 fire;
    logic                 store;
    logic                 expired;
    logic                 has_positive;
    logic                 green;
    logic                 red;
    slot_t                volts_slot;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign volts_slot    = slot_t'({1'b0, volts_reg});

    always_comb
    begin
        has_positive = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (slots_reg[i] > 4'sd0)
            begin
                has_positive = 1'b1;
            end
        end
    end

    always_comb
    begin
        slots_next = slots_reg;
        widx_next  = widx_reg;
        quiet_next = quiet_reg;
        stop_next  = stop_reg;
        pins_next  = pins_reg;
        green      = 1'b0;
        red        = 1'b0;
        store      = (volts_reg != '0) || (widx_reg > INDEX_LAST);
        expired    = quiet_reg > limit_reg;
        widx_eff   = (widx_reg > INDEX_FULL) ? '0 : widx_reg;

        if (fire)
        begin
            if (store)
            begin
                green                  = (widx_reg <= INDEX_LAST);
                quiet_next             = '0;
                slots_next[widx_eff[1:0]] = volts_slot;
                widx_next              = widx_eff + 3'd1;
            end
            else
            begin
                if (quiet_reg != QUIET_MAX)
                begin
                    quiet_next = quiet_reg + 8'd1;
                end
                if (expired && has_positive)
                begin
                    red        = 1'b1;
                    pins_next  = '0;
                    quiet_next = '0;
                    stop_next  = 1'b0;
                    widx_next  = '0;
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        slots_next[i] = SLOT_EMPTY;
                    end
                end
            end

            if (slots_next[3] == 4'sd0)
            begin
                if (slots_next[0] == 4'sd1 && slots_next[2] == 4'sd3)
                begin
                    pins_next[PIN_UP] = 1'b1;
                end
                else if (slots_next[0] == 4'sd3 && slots_next[2] == 4'sd1)
                begin
                    pins_next[PIN_DOWN] = 1'b1;
                end
            end
            else if (slots_next[3] > 4'sd0 && !stop_next)
            begin
                stop_next = 1'b1;
                case (slots_next[3])
                    4'sd1:   pins_next[PIN_BELOW] = 1'b1;
                    4'sd2:   pins_next[PIN_LEVEL] = 1'b1;
                    4'sd3:   pins_next[PIN_ABOVE] = 1'b1;
                    default: ;
                endcase
            end
        end

        out_data_next = {1'b0, pins_next[PIN_ABOVE], pins_next[PIN_LEVEL],
                         pins_next[PIN_BELOW], pins_next[PIN_DOWN], pins_next[PIN_UP],
                         red, green};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= QUIET_RESET;
            widx_reg      <= '0;
            quiet_reg     <= '0;
            stop_reg      <= 1'b0;
            pins_reg      <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slots_reg[i] <= SLOT_EMPTY;
            end
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            slots_reg <= slots_next;
            widx_reg  <= widx_next;
            quiet_reg <= quiet_next;
            stop_reg  <= stop_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            volts_reg <= volts_of(s_axis_tdata[SAMPLE_W-1:0]);
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
